### src/lsl_pkg.sv
package lsl_pkg;

    // field and datapath widths
    localparam int RAW_W      = 16;
    localparam int SCALE_W    = 19;
    localparam int CH_SHIFT   = 10;
    localparam int CH_W       = RAW_W + SCALE_W - CH_SHIFT;
    localparam int QUO_W      = 11;
    localparam int COEF_W     = 10;
    localparam int PROD_W     = CH_W + COEF_W;
    localparam int LUX_SHIFT  = 14;
    localparam int LUX_W      = 21;
    localparam int NUM_SEG    = 8;
    localparam int SEG_W      = 3;
    localparam int GAIN_SHIFT = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    // largest lux the coefficient tables can produce
    localparam logic [LUX_W-1:0] LUX_MAX = 21'd1169008;

    // pipeline layout: scale, divider steps, segment lookup, products, output
    localparam int DIV_STAGES = QUO_W;
    localparam int ST_SCALE   = 0;
    localparam int ST_SEG     = DIV_STAGES + 1;
    localparam int ST_PROD    = DIV_STAGES + 2;
    localparam int ST_OUT     = DIV_STAGES + 3;
    localparam int NUM_STAGES = DIV_STAGES + 4;

    // channel scale per integration time
    localparam logic [SCALE_W-1:0] SCALE_T0   = 19'h07517;
    localparam logic [SCALE_W-1:0] SCALE_T1   = 19'h00FE7;
    localparam logic [SCALE_W-1:0] SCALE_NONE = 19'h00400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTEG = 2'd0,
        CFG_GAIN  = 2'd1,
        CFG_PKG   = 2'd2
    } t_cfg_reg;

    typedef enum logic [CFG_DATA_W-1:0] {
        INTEG_13MS  = 2'd0,
        INTEG_101MS = 2'd1,
        INTEG_402MS = 2'd2
    } t_integ;

    typedef logic [COEF_W-1:0] t_coef;

    // knee, offset and slope per segment, row 0 T/FN/CL, row 1 CS
    localparam t_coef KNEE_TAB [2][NUM_SEG] = '{
        '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a, 10'h29a},
        '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a, 10'h29a}
    };
    localparam t_coef B_TAB [2][NUM_SEG] = '{
        '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000},
        '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}
    };
    localparam t_coef M_TAB [2][NUM_SEG] = '{
        '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000},
        '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b, 10'h000}
    };

    // per-stage load strobes for the divider
    typedef struct packed {
        logic [DIV_STAGES-1:0] load;
    } t_div_ctl;

endpackage

### src/lsl_divider.sv
// restoring divider, one quotient bit per stage, o_sat flags saturation when
// dividend >= 2 * divisor (ratio then lies beyond every knee)
module lsl_divider (
    input  logic                      i_clk,
    input  lsl_pkg::t_div_ctl         i_ctl,
    input  logic [lsl_pkg::CH_W-1:0]  i_dividend,
    input  logic [lsl_pkg::CH_W-1:0]  i_divisor,
    output logic [lsl_pkg::QUO_W-1:0] o_quot,
    output logic                      o_sat,
    output logic [lsl_pkg::CH_W-1:0]  o_dividend,
    output logic [lsl_pkg::CH_W-1:0]  o_divisor
);

    logic [lsl_pkg::CH_W-1:0]  r_rem [lsl_pkg::DIV_STAGES];
    logic [lsl_pkg::CH_W-1:0]  r_num [lsl_pkg::DIV_STAGES];
    logic [lsl_pkg::CH_W-1:0]  r_den [lsl_pkg::DIV_STAGES];
    logic [lsl_pkg::QUO_W-1:0] r_quo [lsl_pkg::DIV_STAGES];
    logic                      r_sat [lsl_pkg::DIV_STAGES];

    logic [lsl_pkg::CH_W-1:0]  n_rem [lsl_pkg::DIV_STAGES];
    logic [lsl_pkg::CH_W-1:0]  n_num [lsl_pkg::DIV_STAGES];
    logic [lsl_pkg::CH_W-1:0]  n_den [lsl_pkg::DIV_STAGES];
    logic [lsl_pkg::QUO_W-1:0] n_quo [lsl_pkg::DIV_STAGES];
    logic                      n_sat [lsl_pkg::DIV_STAGES];

    // first step: integer bit of the quotient plus overflow check,
    // then fractional steps, each from the previous stage's register
    always_comb begin
        logic [lsl_pkg::CH_W:0] v_shift;
        v_shift  = '0;
        n_sat[0] = ({1'b0, i_dividend} >= {i_divisor, 1'b0});
        n_num[0] = i_dividend;
        n_den[0] = i_divisor;
        if (i_dividend >= i_divisor) begin
            n_rem[0] = i_dividend - i_divisor;
            n_quo[0] = lsl_pkg::QUO_W'(1);
        end else begin
            n_rem[0] = i_dividend;
            n_quo[0] = '0;
        end
        for (int s = 1; s < lsl_pkg::DIV_STAGES; s++) begin
            v_shift  = {r_rem[s-1], 1'b0};
            n_sat[s] = r_sat[s-1];
            n_num[s] = r_num[s-1];
            n_den[s] = r_den[s-1];
            if (v_shift >= {1'b0, r_den[s-1]}) begin
                n_rem[s] = lsl_pkg::CH_W'(v_shift - {1'b0, r_den[s-1]});
                n_quo[s] = {r_quo[s-1][lsl_pkg::QUO_W-2:0], 1'b1};
            end else begin
                n_rem[s] = v_shift[lsl_pkg::CH_W-1:0];
                n_quo[s] = {r_quo[s-1][lsl_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < lsl_pkg::DIV_STAGES; s++) begin
            if (i_ctl.load[s]) begin
                r_rem[s] <= n_rem[s];
                r_num[s] <= n_num[s];
                r_den[s] <= n_den[s];
                r_quo[s] <= n_quo[s];
                r_sat[s] <= n_sat[s];
            end
        end
    end

    assign o_quot     = r_quo[lsl_pkg::DIV_STAGES-1];
    assign o_sat      = r_sat[lsl_pkg::DIV_STAGES-1];
    assign o_dividend = r_num[lsl_pkg::DIV_STAGES-1];
    assign o_divisor  = r_den[lsl_pkg::DIV_STAGES-1];

endmodule

### src/light_sensor_lux_calc.sv
// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_broadband_count, i_infrared_count
// output    out        o_valid / i_stall   o_lux
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// fifteen register stages: channel scaling, eleven divider steps (one ratio
// bit each), segment lookup, coefficient products, round and clamp.
// one transaction per cycle in while o_stall is low.
// each stage loads when it is empty or its successor moves, so bubbles
// close up and input is still taken while a result waits on i_stall, until every stage is full.
// synchronous active-low reset clears valid bits and sets config registers to their defaults.
module light_sensor_lux_calc (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [lsl_pkg::RAW_W-1:0]      i_broadband_count,
    input  logic [lsl_pkg::RAW_W-1:0]      i_infrared_count,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [lsl_pkg::LUX_W-1:0]      o_lux,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lsl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // config registers
    logic [1:0] r_integ;
    logic       r_high_gain;
    logic       r_package_cs;

    // pipeline control
    logic [lsl_pkg::NUM_STAGES-1:0] r_valid;
    logic [lsl_pkg::NUM_STAGES-1:0] n_valid;
    logic [lsl_pkg::NUM_STAGES:0]   stage_load;

    // scale stage
    logic [lsl_pkg::SCALE_W-1:0]          scale;
    logic [lsl_pkg::RAW_W+lsl_pkg::SCALE_W-1:0] prod_ch0;
    logic [lsl_pkg::RAW_W+lsl_pkg::SCALE_W-1:0] prod_ch1;
    logic [lsl_pkg::CH_W-1:0]             r_ch0_sc;
    logic [lsl_pkg::CH_W-1:0]             r_ch1_sc;

    // divider
    lsl_pkg::t_div_ctl                    div_ctl;
    logic [lsl_pkg::QUO_W-1:0]            div_quot;
    logic                                 div_sat;
    logic [lsl_pkg::CH_W-1:0]             div_ch1;
    logic [lsl_pkg::CH_W-1:0]             div_ch0;

    // segment stage
    logic [lsl_pkg::QUO_W:0]              n_ratio_sum;
    logic [lsl_pkg::QUO_W-1:0]            n_ratio;
    logic [lsl_pkg::SEG_W-1:0]            n_seg;
    lsl_pkg::t_coef                       n_b;
    lsl_pkg::t_coef                       n_m;
    lsl_pkg::t_coef                       r_b;
    lsl_pkg::t_coef                       r_m;
    logic [lsl_pkg::CH_W-1:0]             r_ch0_sg;
    logic [lsl_pkg::CH_W-1:0]             r_ch1_sg;

    // product and output stages
    logic [lsl_pkg::PROD_W-1:0]           r_pos;
    logic [lsl_pkg::PROD_W-1:0]           r_neg;
    logic [lsl_pkg::PROD_W:0]             n_round;
    logic [lsl_pkg::LUX_W-1:0]            n_lux;
    logic [lsl_pkg::LUX_W-1:0]            r_lux;

    // config writes, out-of-range index ignored
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ      <= lsl_pkg::INTEG_13MS;
            r_high_gain  <= 1'b1;
            r_package_cs <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (lsl_pkg::t_cfg_reg'(i_cfg_index))
                lsl_pkg::CFG_INTEG: r_integ      <= i_cfg_data;
                lsl_pkg::CFG_GAIN:  r_high_gain  <= i_cfg_data[0];
                lsl_pkg::CFG_PKG:   r_package_cs <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage load chain: a stage loads when empty or when its successor loads
    always_comb begin
        stage_load[lsl_pkg::NUM_STAGES] = !i_stall;
        for (int k = lsl_pkg::NUM_STAGES - 1; k >= 0; k--) begin
            stage_load[k] = !r_valid[k] || stage_load[k+1];
        end
    end

    assign o_stall = !stage_load[0];
    assign n_valid = {r_valid[lsl_pkg::NUM_STAGES-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < lsl_pkg::NUM_STAGES; k++) begin
                if (stage_load[k]) begin
                    r_valid[k] <= n_valid[k];
                end
            end
        end
    end

    // channel scale from integration time and gain
    always_comb begin
        case (lsl_pkg::t_integ'(r_integ))
            lsl_pkg::INTEG_13MS:  scale = lsl_pkg::SCALE_T0;
            lsl_pkg::INTEG_101MS: scale = lsl_pkg::SCALE_T1;
            default:              scale = lsl_pkg::SCALE_NONE;
        endcase
        if (!r_high_gain) begin
            scale = scale << lsl_pkg::GAIN_SHIFT;
        end
    end

    assign prod_ch0 = {{lsl_pkg::SCALE_W{1'b0}}, i_broadband_count} * scale;
    assign prod_ch1 = {{lsl_pkg::SCALE_W{1'b0}}, i_infrared_count} * scale;

    always_ff @(posedge i_clk) begin
        if (stage_load[lsl_pkg::ST_SCALE]) begin
            r_ch0_sc <= prod_ch0[lsl_pkg::RAW_W+lsl_pkg::SCALE_W-1:lsl_pkg::CH_SHIFT];
            r_ch1_sc <= prod_ch1[lsl_pkg::RAW_W+lsl_pkg::SCALE_W-1:lsl_pkg::CH_SHIFT];
        end
    end

    // ratio infrared / broadband; zero broadband saturates, which lands in a
    // zero-lux segment just like a zero ratio would with zero broadband
    assign div_ctl.load = stage_load[lsl_pkg::DIV_STAGES:1];

    lsl_divider u_lsl_divider (
        .i_clk      (i_clk),
        .i_ctl      (div_ctl),
        .i_dividend (r_ch1_sc),
        .i_divisor  (r_ch0_sc),
        .o_quot     (div_quot),
        .o_sat      (div_sat),
        .o_dividend (div_ch1),
        .o_divisor  (div_ch0)
    );

    // round the ratio and pick the first segment whose knee covers it; saturation picks the last
    always_comb begin
        n_ratio_sum = {1'b0, div_quot} + (lsl_pkg::QUO_W + 1)'(1);
        n_ratio     = n_ratio_sum[lsl_pkg::QUO_W:1];
        n_seg       = lsl_pkg::SEG_W'(lsl_pkg::NUM_SEG - 1);
        if (!div_sat) begin
            for (int k = lsl_pkg::NUM_SEG - 2; k >= 0; k--) begin
                if (n_ratio <= {1'b0, lsl_pkg::KNEE_TAB[r_package_cs][k]}) begin
                    n_seg = lsl_pkg::SEG_W'(k);
                end
            end
        end
        n_b = lsl_pkg::B_TAB[r_package_cs][n_seg];
        n_m = lsl_pkg::M_TAB[r_package_cs][n_seg];
    end

    always_ff @(posedge i_clk) begin
        if (stage_load[lsl_pkg::ST_SEG]) begin
            r_b      <= n_b;
            r_m      <= n_m;
            r_ch0_sg <= div_ch0;
            r_ch1_sg <= div_ch1;
        end
    end

    // coefficient products at full width
    always_ff @(posedge i_clk) begin
        if (stage_load[lsl_pkg::ST_PROD]) begin
            r_pos <= {{lsl_pkg::COEF_W{1'b0}}, r_ch0_sg} * {{lsl_pkg::CH_W{1'b0}}, r_b};
            r_neg <= {{lsl_pkg::COEF_W{1'b0}}, r_ch1_sg} * {{lsl_pkg::CH_W{1'b0}}, r_m};
        end
    end

    // difference, round, clamp negative to zero
    always_comb begin
        n_round = {1'b0, r_pos} - {1'b0, r_neg}
                + (lsl_pkg::PROD_W + 1)'(1 << (lsl_pkg::LUX_SHIFT - 1));
        if (r_pos <= r_neg) begin
            n_lux = '0;
        end else begin
            n_lux = n_round[lsl_pkg::LUX_SHIFT+lsl_pkg::LUX_W-1:lsl_pkg::LUX_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_load[lsl_pkg::ST_OUT]) begin
            r_lux <= n_lux;
        end
    end

    assign o_valid = r_valid[lsl_pkg::ST_OUT];
    assign o_lux   = r_lux;

endmodule

### src/lsl_checker.sv
module lsl_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic [lsl_pkg::RAW_W-1:0]      i_broadband_count,
    input logic [lsl_pkg::RAW_W-1:0]      i_infrared_count,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [lsl_pkg::LUX_W-1:0]      o_lux,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [lsl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [lsl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // input is held off only when the output holds a valid result blocked by i_stall
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while pipeline has room");

    // a blocked result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_lux)))
        else $error("stalled result changed");

    // lux stays within what the coefficient tables allow
    a_lux_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_lux <= lsl_pkg::LUX_MAX))
        else $error("lux beyond table maximum");

endmodule

bind light_sensor_lux_calc lsl_checker u_lsl_checker (.*);
